// File: src/pfs_pkg.sv
// ----------------------------------------------------------------------------
// pfs_pkg
// Shared types and codes for the periodic frame scheduler.
// ----------------------------------------------------------------------------
package pfs_pkg;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_CMP
    } t_state;

    typedef struct packed {
        logic [10:0] ident;
        logic        periodic;
        logic [31:0] due;
        logic [31:0] period;
    } t_entry;

    typedef struct packed {
        logic        done;
        logic        send_valid;
        logic [10:0] send_id;
        logic        add_accepted;
    } t_result;

endpackage

// File: src/pfs_in_if.sv
// ----------------------------------------------------------------------------
// pfs_in_if
// Request channel: table add or millisecond tick.
// ----------------------------------------------------------------------------
interface pfs_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [10:0] frame_id;
    logic        periodic;
    logic [31:0] first_due;
    logic [31:0] period;
    logic [31:0] now_ms;

    modport source (output valid, op, frame_id, periodic, first_due, period, now_ms,
                    input ready);
    modport sink   (input valid, op, frame_id, periodic, first_due, period, now_ms,
                    output ready);
endinterface

// File: src/pfs_out_if.sv
// ----------------------------------------------------------------------------
// pfs_out_if
// Response channel: one word per request.
// ----------------------------------------------------------------------------
interface pfs_out_if;
    logic        valid;
    logic        ready;
    logic        send_valid;
    logic [10:0] send_id;
    logic        add_accepted;

    modport source (output valid, send_valid, send_id, add_accepted, input ready);
    modport sink   (input valid, send_valid, send_id, add_accepted, output ready);
endinterface

// File: src/pfs_table.sv
// ----------------------------------------------------------------------------
// pfs_table
// Entry memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module pfs_table
    import pfs_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_entry           i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output t_entry           o_rdata
);

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/pfs_ctrl.sv
// ----------------------------------------------------------------------------
// pfs_ctrl
// Sequencer: appends entries and scans the table one entry at a time on ticks.
// ----------------------------------------------------------------------------
module pfs_ctrl
    import pfs_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_enable,
    input  logic             i_start,
    input  logic             i_op,
    input  logic [10:0]      i_frame_id,
    input  logic             i_periodic,
    input  logic [31:0]      i_first_due,
    input  logic [31:0]      i_period,
    input  logic [31:0]      i_now_ms,
    output logic             o_idle,
    output t_result          o_result,
    output logic             o_we,
    output logic [IDX_W-1:0] o_waddr,
    output t_entry           o_wdata,
    output logic [IDX_W-1:0] o_raddr,
    input  t_entry           i_rdata
);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_count, n_count;
    logic [31:0]      r_last, n_last;
    logic [31:0]      r_now, n_now;

    logic hit;
    logic last_entry;
    logic tick_live;
    logic room;

    assign hit        = i_rdata.periodic && (r_now >= i_rdata.due);
    assign last_entry = (CNT_W'(r_idx) + CNT_W'(1)) == r_count;
    assign tick_live  = i_enable && (i_now_ms != r_last);
    assign room       = r_count < CNT_W'(TABLE_DEPTH);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start && i_op == OP_TICK && tick_live && r_count != '0) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (hit || last_entry) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_idx    = r_idx;
        n_count  = r_count;
        n_last   = r_last;
        n_now    = r_now;
        o_we     = 1'b0;
        o_waddr  = r_idx;
        o_wdata  = i_rdata;
        o_raddr  = r_idx;
        o_result = '0;
        o_idle   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_idle = 1'b1;
                if (i_start) begin
                    if (i_op == OP_ADD) begin
                        o_result.done = 1'b1;
                        if (room) begin
                            o_we                  = 1'b1;
                            o_waddr               = r_count[IDX_W-1:0];
                            o_wdata.ident         = i_frame_id;
                            o_wdata.periodic      = i_periodic;
                            o_wdata.due           = i_first_due;
                            o_wdata.period        = i_period;
                            n_count               = r_count + CNT_W'(1);
                            o_result.add_accepted = 1'b1;
                        end
                    end else begin
                        if (tick_live) begin
                            n_last = i_now_ms;
                            n_now  = i_now_ms;
                            n_idx  = '0;
                        end
                        if (!(tick_live && r_count != '0)) begin
                            o_result.done = 1'b1;
                        end
                    end
                end
            end
            S_RD: begin
            end
            S_CMP: begin
                if (hit) begin
                    o_we                = 1'b1;
                    o_wdata.due         = r_now + i_rdata.period;
                    o_result.done       = 1'b1;
                    o_result.send_valid = 1'b1;
                    o_result.send_id    = i_rdata.ident;
                end else if (last_entry) begin
                    o_result.done = 1'b1;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_last  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_last  <= n_last;
        end
        r_idx <= n_idx;
        r_now <= n_now;
    end

endmodule

// File: src/periodic_frame_scheduler_core.sv
// ----------------------------------------------------------------------------
// periodic_frame_scheduler_core
// Table of periodic remote-request frames with a sequential due-time scan.
// ----------------------------------------------------------------------------
// Each request word returns exactly one response word. An add appends to the
// table if there is room and is refused otherwise. A live tick (enabled, new
// time, non-empty table) scans the entry memory from index 0, one entry at a
// time (registered read, then compare and due-time update through one 32-bit
// adder), and stops at the first due periodic entry or at the last entry.
// The block takes no new request until the previous response word has been
// taken.
module periodic_frame_scheduler_core
    import pfs_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  logic     i_cfg_wdata,
    pfs_in_if.sink   i_req,
    pfs_out_if.source o_rsp
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic             r_enable;
    logic             r_out_valid;
    logic             r_send_valid;
    logic [10:0]      r_send_id;
    logic             r_add_accepted;

    logic             idle;
    logic             start;
    t_result          result;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    t_entry           mem_wdata;
    t_entry           mem_rdata;

    assign i_req.ready = idle && !r_out_valid;
    assign start       = i_req.valid && i_req.ready;

    pfs_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_enable    (r_enable),
        .i_start     (start),
        .i_op        (i_req.op),
        .i_frame_id  (i_req.frame_id),
        .i_periodic  (i_req.periodic),
        .i_first_due (i_req.first_due),
        .i_period    (i_req.period),
        .i_now_ms    (i_req.now_ms),
        .o_idle      (idle),
        .o_result    (result),
        .o_we        (mem_we),
        .o_waddr     (mem_waddr),
        .o_wdata     (mem_wdata),
        .o_raddr     (mem_raddr),
        .i_rdata     (mem_rdata)
    );

    pfs_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_enable <= i_cfg_wdata;
            end
            if (result.done) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (result.done) begin
            r_send_valid   <= result.send_valid;
            r_send_id      <= result.send_id;
            r_add_accepted <= result.add_accepted;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.send_valid   = r_send_valid;
    assign o_rsp.send_id      = r_send_id;
    assign o_rsp.add_accepted = r_add_accepted;

endmodule
